FILE: hw/rtl/triangle_scanline_rasterizer_macros.svh
// Assertion helpers shared by the rasterizer RTL.
// Both expect clk and rst_n in the scope where they are used.
`ifndef TRIANGLE_SCANLINE_RASTERIZER_MACROS_SVH
`define TRIANGLE_SCANLINE_RASTERIZER_MACROS_SVH

// Same-cycle implication.
`define TSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tsr_pkg.sv
`default_nettype none

package tsr_pkg;

    localparam int COORD_BITS = 15;

    // Input channel command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Request to the shared edge unit: x0 + dx*dr/dy.
    typedef struct packed {
        logic                  start;
        coord_t                x0;
        logic [COORD_BITS:0]   dx;
        logic [COORD_BITS-1:0] dr;
        logic [COORD_BITS-1:0] dy;
    } edge_req_t;

    typedef struct packed {
        logic   done;
        coord_t x;
    } edge_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/triangle_scanline_rasterizer.sv
// Load transaction: the sort and classify states, then the column and span-end
// edge divisions of the first row; a flat line needs none.
// Step transaction: one pixel per cycle inside a span unless the output stalls;
// after a row's closing step, transactions wait for the shared multiply/divide edge unit.
// Reset (asynchronous, active low) leaves no triangle loaded; steps then give no pixel.
`default_nettype none
`include "triangle_scanline_rasterizer_macros.svh"

module triangle_scanline_rasterizer (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             command,
    input  wire logic signed [tsr_pkg::COORD_BITS-1:0] ax,
    input  wire logic signed [tsr_pkg::COORD_BITS-1:0] ay,
    input  wire logic signed [tsr_pkg::COORD_BITS-1:0] bx,
    input  wire logic signed [tsr_pkg::COORD_BITS-1:0] by_coord,
    input  wire logic signed [tsr_pkg::COORD_BITS-1:0] cx,
    input  wire logic signed [tsr_pkg::COORD_BITS-1:0] cy,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [tsr_pkg::COORD_BITS-1:0] pixel_x,
    output logic signed [tsr_pkg::COORD_BITS-1:0] pixel_y,
    output logic                                  last_pixel
);
    import tsr_pkg::*;

    localparam int CB = COORD_BITS;

    localparam coord_t COORD_ONE = coord_t'(1);

    // Main sequencer. The three sort states run a single compare-exchange
    // on a fixed vertex pair each; the GO/WAIT pairs drive the edge unit.
    typedef enum logic [8:0] {
        S_READY    = 9'b000000001,
        S_SORT0    = 9'b000000010,
        S_SORT1    = 9'b000000100,
        S_SORT2    = 9'b000001000,
        S_CLASS    = 9'b000010000,
        S_COL_GO   = 9'b000100000,
        S_COL_WAIT = 9'b001000000,
        S_END_GO   = 9'b010000000,
        S_END_WAIT = 9'b100000000
    } state_t;

    // Which part of the triangle is being walked.
    typedef enum logic [3:0] {
        SEC_IDLE  = 4'b0001,
        SEC_UPPER = 4'b0010,
        SEC_LOWER = 4'b0100,
        SEC_FLAT  = 4'b1000
    } sec_t;

    state_t    state_reg, state_next;
    sec_t      section_reg, section_next;
    coord_t    row_reg, row_next;
    coord_t    column_reg, column_next;
    coord_t    span_end_reg, span_end_next;
    logic      out_valid_reg, out_valid_next;
    coord_t    pix_x_reg, pix_x_next;
    coord_t    pix_y_reg, pix_y_next;
    logic      last_pixel_reg, last_pixel_next;
    coord_t    vx_reg [3];
    coord_t    vx_next [3];
    coord_t    vy_reg [3];
    coord_t    vy_next [3];

    logic      in_fire;
    logic      emit;
    logic      is_last;

    // Sort network operands.
    logic      sort_hi;
    coord_t    px, py, qx, qy;
    logic      swap;

    // Edge operand selection.
    logic      col_go;
    logic      end_go;
    logic      a_is_v1;
    logic      b_is_v1;
    coord_t    ea_x, ea_y, eb_x, eb_y;
    logic [CB:0] dx_w, dy_w, dr_w;
    edge_req_t req;
    edge_rsp_t rsp;

    // A transaction is only taken with a free output slot, so a pixel never
    // has to wait inside the sequencer.
    assign in_ready = (state_reg == S_READY) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;
    assign emit     = in_fire && (command == CMD_STEP) && (section_reg != SEC_IDLE);

    // The pixel is the last one when its span is finished and no row follows.
    always_comb
    begin
        is_last = 1'b0;
        if (column_reg == span_end_reg)
        begin
            case (section_reg)
                SEC_UPPER: is_last = !(row_reg < vy_reg[1]) && !(vy_reg[1] < vy_reg[2]);
                SEC_LOWER: is_last = !(row_reg < vy_reg[2]);
                SEC_FLAT:  is_last = 1'b1;
                default:   is_last = 1'b0;
            endcase
        end
    end

    // Sorting order is by y, ties broken by x. The middle pass compares the
    // second and third vertices, the outer passes the first and second.
    assign sort_hi = (state_reg == S_SORT1);
    assign px      = sort_hi ? vx_reg[1] : vx_reg[0];
    assign py      = sort_hi ? vy_reg[1] : vy_reg[0];
    assign qx      = sort_hi ? vx_reg[2] : vx_reg[1];
    assign qy      = sort_hi ? vy_reg[2] : vy_reg[1];
    assign swap    = (qy < py) || ((qy == py) && (qx < px));

    // The first span end of a row lies on the short edge of the current part
    // (P0-P1 in the upper part, P1-P2 in the lower); the second on P0-P2.
    assign col_go  = (state_reg == S_COL_GO);
    assign end_go  = (state_reg == S_END_GO);
    assign a_is_v1 = col_go && (section_reg == SEC_LOWER);
    assign b_is_v1 = col_go && (section_reg == SEC_UPPER);
    assign ea_x    = a_is_v1 ? vx_reg[1] : vx_reg[0];
    assign ea_y    = a_is_v1 ? vy_reg[1] : vy_reg[0];
    assign eb_x    = b_is_v1 ? vx_reg[1] : vx_reg[2];
    assign eb_y    = b_is_v1 ? vy_reg[1] : vy_reg[2];
    assign dx_w    = {eb_x[CB-1], eb_x} - {ea_x[CB-1], ea_x};
    assign dy_w    = {eb_y[CB-1], eb_y} - {ea_y[CB-1], ea_y};
    assign dr_w    = {row_reg[CB-1], row_reg} - {ea_y[CB-1], ea_y};

    // Within a part the row never leaves the edge's y range, so both the
    // height and the row offset are non-negative and fit in CB bits.
    assign req.start = col_go || end_go;
    assign req.x0    = ea_x;
    assign req.dx    = dx_w;
    assign req.dr    = dr_w[CB-1:0];
    assign req.dy    = dy_w[CB-1:0];

    tsr_edge_unit u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_comb
    begin
        state_next      = state_reg;
        section_next    = section_reg;
        row_next        = row_reg;
        column_next     = column_reg;
        span_end_next   = span_end_reg;
        pix_x_next      = pix_x_reg;
        pix_y_next      = pix_y_reg;
        last_pixel_next = last_pixel_reg;
        vx_next         = vx_reg;
        vy_next         = vy_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;

        case (state_reg)
            S_READY:
            begin
                if (in_fire && (command == CMD_LOAD))
                begin
                    // A load replaces any triangle still in progress.
                    vx_next[0] = ax;
                    vy_next[0] = ay;
                    vx_next[1] = bx;
                    vy_next[1] = by_coord;
                    vx_next[2] = cx;
                    vy_next[2] = cy;
                    state_next = S_SORT0;
                end
                else if (emit)
                begin
                    pix_x_next      = column_reg;
                    pix_y_next      = row_reg;
                    last_pixel_next = is_last;
                    out_valid_next  = 1'b1;
                    if (column_reg != span_end_reg)
                    begin
                        column_next = (column_reg < span_end_reg) ?
                                      column_reg + COORD_ONE : column_reg - COORD_ONE;
                    end
                    else if (is_last)
                    begin
                        section_next = SEC_IDLE;
                    end
                    else
                    begin
                        // Next row; the upper part hands over to the lower
                        // part once it passes the middle vertex.
                        row_next   = row_reg + COORD_ONE;
                        state_next = S_COL_GO;
                        if ((section_reg == SEC_UPPER) && !(row_reg < vy_reg[1]))
                        begin
                            section_next = SEC_LOWER;
                        end
                    end
                end
            end
            S_SORT0, S_SORT1, S_SORT2:
            begin
                if (swap)
                begin
                    if (sort_hi)
                    begin
                        vx_next[1] = qx;
                        vy_next[1] = qy;
                        vx_next[2] = px;
                        vy_next[2] = py;
                    end
                    else
                    begin
                        vx_next[0] = qx;
                        vy_next[0] = qy;
                        vx_next[1] = px;
                        vy_next[1] = py;
                    end
                end
                case (state_reg)
                    S_SORT0: state_next = S_SORT1;
                    S_SORT1: state_next = S_SORT2;
                    default: state_next = S_CLASS;
                endcase
            end
            S_CLASS:
            begin
                row_next = vy_reg[0];
                if (vy_reg[0] < vy_reg[1])
                begin
                    section_next = SEC_UPPER;
                    state_next   = S_COL_GO;
                end
                else if (vy_reg[1] < vy_reg[2])
                begin
                    // Flat top: the lower part starts on the top row.
                    section_next = SEC_LOWER;
                    state_next   = S_COL_GO;
                end
                else
                begin
                    // Fully flat: a single span between the outer vertices.
                    section_next  = SEC_FLAT;
                    column_next   = vx_reg[0];
                    span_end_next = vx_reg[2];
                    state_next    = S_READY;
                end
            end
            S_COL_GO:
            begin
                state_next = S_COL_WAIT;
            end
            S_COL_WAIT:
            begin
                if (rsp.done)
                begin
                    column_next = rsp.x;
                    state_next  = S_END_GO;
                end
            end
            S_END_GO:
            begin
                state_next = S_END_WAIT;
            end
            S_END_WAIT:
            begin
                if (rsp.done)
                begin
                    span_end_next = rsp.x;
                    state_next    = S_READY;
                end
            end
            default:
            begin
                state_next = S_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_READY;
            section_reg   <= SEC_IDLE;
            row_reg       <= '0;
            column_reg    <= '0;
            span_end_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            section_reg   <= section_next;
            row_reg       <= row_next;
            column_reg    <= column_next;
            span_end_reg  <= span_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Vertex store and output payload carry no reset.
    always_ff @(posedge clk)
    begin
        vx_reg         <= vx_next;
        vy_reg         <= vy_next;
        pix_x_reg      <= pix_x_next;
        pix_y_reg      <= pix_y_next;
        last_pixel_reg <= last_pixel_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pix_x_reg;
    assign pixel_y    = pix_y_reg;
    assign last_pixel = last_pixel_reg;

    `TSR_ASSERT_NOW(a_wait_in_sloped_part,
        (state_reg == S_COL_WAIT) || (state_reg == S_END_WAIT),
        (section_reg == SEC_UPPER) || (section_reg == SEC_LOWER),
        "edge wait outside a sloped part")
    `TSR_ASSERT_NOW(a_done_only_waiting, rsp.done,
        (state_reg == S_COL_WAIT) || (state_reg == S_END_WAIT),
        "edge result arrived unexpectedly")
    `TSR_ASSERT_NEXT(a_last_closes_triangle, emit && is_last,
        (section_reg == SEC_IDLE) && out_valid_reg && last_pixel_reg,
        "last pixel did not close the triangle")

endmodule

`default_nettype wire

FILE: hw/rtl/tsr_edge_unit.sv
`default_nettype none
`include "triangle_scanline_rasterizer_macros.svh"

module tsr_edge_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tsr_pkg::edge_req_t req,
    output tsr_pkg::edge_rsp_t      rsp
);
    import tsr_pkg::*;

    localparam int CB        = COORD_BITS;
    localparam int DIV_STEPS = 2 * CB;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_MUL  = 4'b0010,
        U_DIV  = 4'b0100,
        U_FIX  = 4'b1000
    } ustate_t;

    ustate_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [CB:0]      dx_reg, dx_next;
    logic [CB-1:0]    dr_reg, dr_next;
    logic [CB-1:0]    dy_reg, dy_next;
    coord_t           x0_reg, x0_next;
    logic             neg_reg, neg_next;
    logic [CB-1:0]    rem_reg, rem_next;
    logic [2*CB-1:0]  quo_reg, quo_next;
    coord_t           res_reg, res_next;

    logic [CB:0]      mag;
    logic [2*CB-1:0]  prod;
    logic [CB:0]      rem_sh;
    logic [CB:0]      diff;
    logic             ge;
    logic [CB:0]      q_ext;
    logic [CB:0]      q_sgn;
    logic [CB:0]      sum;

    // Magnitude product, then restoring division one quotient bit per cycle.
    assign mag    = dx_reg[CB] ? -dx_reg : dx_reg;
    assign prod   = {{CB{1'b0}}, mag[CB-1:0]} * {{CB{1'b0}}, dr_reg};
    assign rem_sh = {rem_reg, quo_reg[2*CB-1]};
    assign diff   = rem_sh - {1'b0, dy_reg};
    assign ge     = rem_sh >= {1'b0, dy_reg};
    assign q_ext  = {1'b0, quo_reg[CB-1:0]};
    assign q_sgn  = neg_reg ? -q_ext : q_ext;
    assign sum    = {x0_reg[CB-1], x0_reg} + q_sgn;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        dx_next    = dx_reg;
        dr_next    = dr_reg;
        dy_next    = dy_reg;
        x0_next    = x0_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        res_next   = res_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    dx_next    = req.dx;
                    dr_next    = req.dr;
                    dy_next    = req.dy;
                    x0_next    = req.x0;
                    state_next = U_MUL;
                end
            end
            U_MUL:
            begin
                neg_next = dx_reg[CB];
                rem_next = '0;
                cnt_next = '0;
                if (dy_reg == '0)
                begin
                    // A level edge contributes its start x unchanged.
                    quo_next   = '0;
                    state_next = U_FIX;
                end
                else
                begin
                    quo_next   = prod;
                    state_next = U_DIV;
                end
            end
            U_DIV:
            begin
                rem_next = ge ? diff[CB-1:0] : rem_sh[CB-1:0];
                quo_next = {quo_reg[2*CB-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = U_FIX;
                end
            end
            U_FIX:
            begin
                res_next   = sum[CB-1:0];
                done_next  = 1'b1;
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dr_reg  <= dr_next;
        dy_reg  <= dy_next;
        x0_reg  <= x0_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.x    = res_reg;

    `TSR_ASSERT_NOW(a_start_when_idle, req.start, state_reg == U_IDLE, "edge unit started while busy")
    `TSR_ASSERT_NOW(a_rem_below_divisor, state_reg == U_DIV, rem_reg < dy_reg, "division remainder out of range")
    `TSR_ASSERT_NEXT(a_fix_gives_done, state_reg == U_FIX, done_reg, "edge result not flagged done")

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // The block takes load and step transactions on its input channel. A load
    // sorts three vertices and prepares the first span; each step while a
    // triangle is active returns one covered pixel on the output channel. A step
    // with no triangle active is swallowed without a result.
    //
    // A scoreboard process watches both channels at the rising clock edge. It
    // keeps its own copy of the rasterizer state: sorted vertices, current row,
    // current column, span end and section. Every accepted step that should
    // produce a pixel pushes the predicted pixel onto a queue. Every accepted
    // pixel is compared field by field against the oldest prediction.
    //
    // Stimulus is a handful of directed shapes followed by a long random mix.
    // The directed shapes are a step on an idle block, a single-row triangle, a
    // flat top, a flat bottom, a triangle collapsed to one point, and reloads at
    // the coordinate extremes. The random mix is mostly small triangles walked to
    // their last pixel, plus full-range triangles that are abandoned by a reload
    // and plain noise. Both sides of the block insert random idle cycles, except
    // in one burst section where neither side idles.

    import tsr_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 3;
    localparam int IDLE_PERCENT  = 36;
    // A row change makes the block wait on the edge unit for two divisions, so
    // reaching QUIET_LIMIT with no transaction at all means the block is hung.
    localparam int QUIET_LIMIT   = 4000;
    // Cycles allowed after the last expected pixel for any stray output.
    localparam int SETTLE_CYCLES = 300;
    localparam int BURST_ITEMS   = 200;
    localparam int RANDOM_ITEMS  = 1300;

    localparam coord_t COORD_MIN = coord_t'(1 << (COORD_BITS - 1));
    localparam coord_t COORD_MAX = coord_t'((1 << (COORD_BITS - 1)) - 1);

    // Which part of the triangle the walker is in.
    typedef enum logic [1:0] {
        SEC_IDLE,
        SEC_UPPER,
        SEC_LOWER,
        SEC_FLAT
    } span_section_e;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    logic   command;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by_coord;
    coord_t cx;
    coord_t cy;
    logic   out_valid;
    logic   out_ready = 1'b0;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;

    // Predicted rasterizer state. It follows the accepted transactions, so the
    // stimulus code can also read it at a falling edge to see whether the
    // current triangle is finished.
    coord_t        vert_x [3];
    coord_t        vert_y [3];
    coord_t        walk_row = '0;
    coord_t        walk_col = '0;
    coord_t        walk_end = '0;
    span_section_e walk_section = SEC_IDLE;

    pixel_t expected_pixels [$];

    int error_count    = 0;
    int load_count     = 0;
    int pixel_count    = 0;
    int triangle_count = 0;
    // Loads plus steps that produce a pixel; ignored steps do not count.
    int useful_items   = 0;

    bit sender_gaps     = 1'b1;
    bit receiver_stalls = 1'b1;

    triangle_scanline_rasterizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .ax         (ax),
        .ay         (ay),
        .bx         (bx),
        .by_coord   (by_coord),
        .cx         (cx),
        .cy         (cy),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Pixel predictor
    // ------------------------------------------------------------------

    // Column where edge a-b crosses row r. The division truncates toward
    // zero, which is what longint division does. A flat edge yields its
    // first vertex.
    function automatic longint edge_at(input int a, input int b, input longint r);
        longint x0;
        longint y0;
        longint x1;
        longint y1;
        longint dy;
        x0 = vert_x[a];
        y0 = vert_y[a];
        x1 = vert_x[b];
        y1 = vert_y[b];
        dy = y1 - y0;
        if (dy == 0)
            return x0;
        return x0 + ((x1 - x0) * (r - y0)) / dy;
    endfunction

    function automatic void begin_span();
        case (walk_section)
            SEC_UPPER:
            begin
                walk_col = coord_t'(edge_at(0, 1, walk_row));
                walk_end = coord_t'(edge_at(0, 2, walk_row));
            end
            SEC_LOWER:
            begin
                walk_col = coord_t'(edge_at(1, 2, walk_row));
                walk_end = coord_t'(edge_at(0, 2, walk_row));
            end
            default:
            begin
                walk_col = vert_x[0];
                walk_end = vert_x[2];
            end
        endcase
    endfunction

    // Swap vertices i and i+1 if they are out of order by y, then by x.
    function automatic void order_vertices(input int i);
        coord_t t;
        if (vert_y[i + 1] < vert_y[i] ||
            (vert_y[i + 1] == vert_y[i] && vert_x[i + 1] < vert_x[i]))
        begin
            t = vert_x[i];
            vert_x[i] = vert_x[i + 1];
            vert_x[i + 1] = t;
            t = vert_y[i];
            vert_y[i] = vert_y[i + 1];
            vert_y[i + 1] = t;
        end
    endfunction

    function automatic void load_triangle(input coord_t a_x, a_y, b_x, b_y, c_x, c_y);
        vert_x[0] = a_x;
        vert_y[0] = a_y;
        vert_x[1] = b_x;
        vert_y[1] = b_y;
        vert_x[2] = c_x;
        vert_y[2] = c_y;
        order_vertices(0);
        order_vertices(1);
        order_vertices(0);
        // Pick the first section: an upper part if the top vertex stands
        // alone, a lower part for a flat top, a single span if all y agree.
        if (vert_y[0] < vert_y[1])
            walk_section = SEC_UPPER;
        else if (vert_y[1] < vert_y[2])
            walk_section = SEC_LOWER;
        else
            walk_section = SEC_FLAT;
        walk_row = vert_y[0];
        begin_span();
    endfunction

    // Pixel for one step on an active triangle, and advance the walker.
    function automatic pixel_t next_pixel();
        pixel_t pix;
        pix.x = walk_col;
        pix.y = walk_row;
        pix.last = 1'b0;
        if (walk_col != walk_end)
        begin
            walk_col = (walk_col < walk_end) ? walk_col + coord_t'(1)
                                             : walk_col - coord_t'(1);
        end
        else if (walk_section == SEC_UPPER)
        begin
            if (walk_row < vert_y[1])
            begin
                walk_row++;
                begin_span();
            end
            else if (vert_y[1] < vert_y[2])
            begin
                // The lower part picks up on the row below the middle vertex.
                walk_section = SEC_LOWER;
                walk_row++;
                begin_span();
            end
            else
            begin
                pix.last = 1'b1;
            end
        end
        else if (walk_section == SEC_LOWER)
        begin
            if (walk_row < vert_y[2])
            begin
                walk_row++;
                begin_span();
            end
            else
            begin
                pix.last = 1'b1;
            end
        end
        else
        begin
            pix.last = 1'b1;
        end
        if (pix.last)
            walk_section = SEC_IDLE;
        return pix;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: both channels are sampled at the rising edge. An input
    // transaction is predicted before an output transaction in the same
    // cycle is checked, so even a same-cycle result finds its prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (command == CMD_LOAD)
                begin
                    load_count++;
                    load_triangle(ax, ay, bx, by_coord, cx, cy);
                end
                else if (walk_section != SEC_IDLE)
                begin
                    expected_pixels.push_back(next_pixel());
                end
            end
            if (out_valid && out_ready)
            begin
                pixel_count++;
                if (expected_pixels.size() == 0)
                begin
                    error_count++;
                    $error("pixel (%0d, %0d) arrived with no step waiting for it",
                           pixel_x, pixel_y);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_x !== want.x)
                    begin
                        error_count++;
                        $error("pixel_x mismatch: expected %0d, actual %0d", want.x, pixel_x);
                    end
                    if (pixel_y !== want.y)
                    begin
                        error_count++;
                        $error("pixel_y mismatch: expected %0d, actual %0d", want.y, pixel_y);
                    end
                    if (last_pixel !== want.last)
                    begin
                        error_count++;
                        $error("last_pixel mismatch: expected %0d, actual %0d",
                               want.last, last_pixel);
                    end
                    if (want.last)
                        triangle_count++;
                end
            end
        end
    end

    // Receiver: ready changes only at the falling edge.
    always @(negedge clk)
    begin
        if (receiver_stalls)
            out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        else
            out_ready <= 1'b1;
    end

    // Watchdog: counts consecutive cycles in which no transaction completes on
    // either channel, and ends the run when the count reaches QUIET_LIMIT.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Every helper is entered and left at a falling edge.
    // ------------------------------------------------------------------

    // Drive one input transaction and hold it until the block takes it.
    task automatic send_item(input logic cmd, input coord_t a_x, a_y, b_x, b_y, c_x, c_y);
        while (sender_gaps && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        if (cmd == CMD_LOAD || walk_section != SEC_IDLE)
            useful_items++;
        in_valid <= 1'b1;
        command  <= cmd;
        ax       <= a_x;
        ay       <= a_y;
        bx       <= b_x;
        by_coord <= b_y;
        cx       <= c_x;
        cy       <= c_y;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // A step carries random coordinates; the block must ignore them.
    task automatic send_step();
        send_item(CMD_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    endtask

    task automatic step_to_last_pixel();
        while (walk_section != SEC_IDLE)
            send_step();
    endtask

    // Hold the input channel quiet until every predicted pixel has come out.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_pixels.size() != 0)
            @(negedge clk);
    endtask

    function automatic int place_center(input int lo, input int hi);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return lo;
        if (roll == 1)
            return hi;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Load a small triangle somewhere in the coordinate range, often pressed
    // against an edge of it, with ties forced now and then so that the flat
    // and degenerate shapes keep coming up.
    task automatic send_small_triangle();
        int     spread;
        int     roll;
        int     mid_x;
        int     mid_y;
        coord_t px [3];
        coord_t py [3];
        roll = $urandom_range(0, 9);
        spread = (roll < 5) ? 2 : (roll < 8) ? 5 : 12;
        mid_x = place_center(int'(COORD_MIN) + spread, int'(COORD_MAX) - spread);
        mid_y = place_center(int'(COORD_MIN) + spread, int'(COORD_MAX) - spread);
        for (int i = 0; i < 3; i++)
        begin
            px[i] = coord_t'(mid_x + int'($urandom_range(0, 2 * spread)) - spread);
            py[i] = coord_t'(mid_y + int'($urandom_range(0, 2 * spread)) - spread);
        end
        case ($urandom_range(0, 9))
            0:
            begin
                py[1] = py[0];
                py[2] = py[0];
            end
            1: py[1] = py[0];
            2:
            begin
                px[1] = px[0];
                py[1] = py[0];
            end
            3: px[2] = px[0];
            default: ;
        endcase
        send_item(CMD_LOAD, px[0], py[0], px[1], py[1], px[2], py[2]);
    endtask

    // The random mix: mostly complete small triangles, some abandoned ones,
    // full-range triangles cut short by the next load, and raw noise.
    task automatic run_triangle_mix(input int target);
        int roll;
        while (useful_items < target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
            begin
                send_small_triangle();
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(0, 5)) send_step();
                else
                    step_to_last_pixel();
                // An extra step now and then lands on an idle block.
                if ($urandom_range(0, 9) == 0)
                    send_step();
            end
            else if (roll < 85)
            begin
                send_item(CMD_LOAD, coord_t'($urandom), coord_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom));
                repeat ($urandom_range(1, 8)) send_step();
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_item(CMD_LOAD, coord_t'($urandom), coord_t'($urandom),
                                  coord_t'($urandom), coord_t'($urandom),
                                  coord_t'($urandom), coord_t'($urandom));
                    else
                        send_step();
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Nothing loaded yet: the step must vanish without a pixel. The pause
    // afterwards gives any stray pixel time to show up as unexpected.
    task automatic test_idle_step();
        send_step();
        wait_results_drained();
    endtask

    // All three vertices on one row: one span from the leftmost to the
    // rightmost vertex, then a step on the finished triangle.
    task automatic test_single_row();
        send_item(CMD_LOAD, coord_t'(1), coord_t'(4), coord_t'(-1), coord_t'(4),
                  coord_t'(0), coord_t'(4));
        step_to_last_pixel();
        send_step();
    endtask

    // Two vertices share the top row, so the walk starts in the lower part.
    task automatic test_flat_top();
        send_item(CMD_LOAD, coord_t'(0), coord_t'(0), coord_t'(1), coord_t'(0),
                  coord_t'(0), coord_t'(1));
        step_to_last_pixel();
    endtask

    // The first load has a flat bottom, so only its upper part is walked.
    // The second walks both parts; both divide negative x deltas.
    task automatic test_flat_bottom();
        send_item(CMD_LOAD, coord_t'(0), coord_t'(0), coord_t'(-1), coord_t'(1),
                  coord_t'(1), coord_t'(1));
        step_to_last_pixel();
        send_item(CMD_LOAD, coord_t'(2), coord_t'(-3), coord_t'(-1), coord_t'(0),
                  coord_t'(0), coord_t'(1));
        step_to_last_pixel();
    endtask

    // Every vertex in the same place: exactly one pixel.
    task automatic test_single_point();
        send_item(CMD_LOAD, coord_t'(5), coord_t'(-3), coord_t'(5), coord_t'(-3),
                  coord_t'(5), coord_t'(-3));
        step_to_last_pixel();
    endtask

    // Triangles spanning the whole coordinate range, each left after two pixels;
    // the first is replaced by a new load.
    task automatic test_reload_extremes();
        send_item(CMD_LOAD, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX);
        repeat (2) send_step();
        send_item(CMD_LOAD, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        repeat (2) send_step();
        wait_results_drained();
    endtask

    // Neither side idles: steps and pixels go back to back.
    task automatic test_back_to_back();
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        run_triangle_mix(useful_items + BURST_ITEMS);
        wait_results_drained();
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    task automatic test_random_triangles();
        run_triangle_mix(useful_items + RANDOM_ITEMS);
        wait_results_drained();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        command  = CMD_STEP;
        ax       = '0;
        ay       = '0;
        bx       = '0;
        by_coord = '0;
        cx       = '0;
        cy       = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_step();
        test_single_row();
        test_flat_top();
        test_flat_bottom();
        test_single_point();
        test_reload_extremes();
        test_back_to_back();
        test_random_triangles();

        // Everything predicted has arrived; leave room for a stray pixel.
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Ran %0d loads and checked %0d pixels, %0d triangles walked to the end.",
                 load_count, pixel_count, triangle_count);
        $display("Shapes: single row, flat top, flat bottom, single point, full range, reloads.");
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/tsr_pkg.sv
hw/rtl/tsr_edge_unit.sv
hw/rtl/triangle_scanline_rasterizer.sv
dv/tb_top.sv
